@@ design/nearest_palette_color_mapper_assert.svh @@
// ----------------------------------------------------------------------------
// nearest palette color mapper assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_MAPPER_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define NPCM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("npcm assertion failed");

// next-cycle implication
`define NPCM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("npcm assertion failed");

`else

`define NPCM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define NPCM_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ design/npcm_pkg.sv @@
// ----------------------------------------------------------------------------
// npcm_pkg
// shared widths, codes and helpers of the nearest palette color mapper
// ----------------------------------------------------------------------------
package npcm_pkg;

   localparam int COLOR_W = 24;
   localparam int CHAN_W  = 8;
   localparam int INDEX_W = 8;
   localparam int SIZE_W  = 9;
   localparam int SQ_W    = 2 * CHAN_W;
   localparam int DIST_W  = SQ_W + 2;

   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [CHAN_W-1:0]  chan_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [SIZE_W-1:0]  size_type;
   typedef logic [SQ_W-1:0]    sq_type;
   typedef logic [DIST_W-1:0]  dist_type;

   // request opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_MAP   = 1'b1;

   // csr register index
   localparam logic REG_PALETTE_SIZE = 1'b0;

   localparam size_type PALETTE_SIZE_RESET = 9'd256;

   function automatic chan_type abs_diff(input chan_type a, input chan_type b);
      chan_type d;
      d = (a > b) ? (a - b) : (b - a);
      return d;
   endfunction

   function automatic sq_type square(input chan_type d);
      sq_type r;
      r = sq_type'(d) * sq_type'(d);
      return r;
   endfunction

endpackage

@@ design/npcm_if.sv @@
// ----------------------------------------------------------------------------
// npcm request and response channels
// valid/ready channel bundles with source and sink views
// ----------------------------------------------------------------------------
interface npcm_req_if import npcm_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      opcode;
   index_type entry_index;
   color_type rgb_color;
   logic      last_pixel;

   modport source (output valid, opcode, entry_index, rgb_color, last_pixel, input ready);
   modport sink (input valid, opcode, entry_index, rgb_color, last_pixel, output ready);
endinterface

interface npcm_rsp_if import npcm_pkg::*; ();
   logic      valid;
   logic      ready;
   index_type palette_index;
   logic      is_last;

   modport source (output valid, palette_index, is_last, input ready);
   modport sink (input valid, palette_index, is_last, output ready);
endinterface

@@ design/npcm_ram.sv @@
// ----------------------------------------------------------------------------
// npcm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module npcm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/nearest_palette_color_mapper.sv @@
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper
// maps rgb888 pixels to the index of the nearest palette color
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          carries
//   req       in         valid / ready      opcode, entry_index, rgb_color,
//                                           last_pixel
//   rsp       out        valid / ready      palette_index, is_last
//   csr       in         apb psel/penable   palette_size at byte address 0
//
// a write request stores one palette color
// a map request scans n entries, with n the searched entry count
//   (palette_size capped at the store depth), and none with an empty
//   palette: the scan reads one entry per cycle
// one request is worked on at a time; the next is taken once the result is
//   loaded, while that result may still wait in the output register
// a stalled rsp holds the finished index until taken; the scan end waits
// synchronous active-high reset clears control state only; the palette ram
//   is not cleared and must be written before it is searched
//
`include "nearest_palette_color_mapper_assert.svh"

module nearest_palette_color_mapper import npcm_pkg::*; #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   npcm_req_if.sink    req,
   npcm_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
   localparam int CNT_W  = $clog2(PALETTE_ENTRIES + 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_sat;
   size_type          palette_size_ff;
   color_type         color_ff;
   logic              last_ff;

   // read pipeline: v1 marks ram data, v2 marks squared channel distances
   logic              v1_ff, v2_ff;
   logic [ADDR_W-1:0] idx1_ff, idx2_ff;
   sq_type            sq_r_ff, sq_g_ff, sq_b_ff;
   dist_type          dist_sum;

   // running best
   logic              first_ff;
   index_type         best_index_ff;
   dist_type          best_dist_ff;

   // output register
   logic              rsp_valid_ff;
   index_type         rsp_index_ff;
   logic              rsp_last_ff;

   logic              req_fire;
   logic              csr_write;
   logic              rd_en;
   logic              out_load;
   logic              wr_en;
   color_type         rd_data;

   assign req_fire  = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);

   // csr access, single register at word 0
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_PALETTE_SIZE);
   assign csr_prdata = (csr_paddr[2] == REG_PALETTE_SIZE) ? 32'(palette_size_ff) : '0;

   // oversized palette_size saturates to the store depth
   assign count_sat = (palette_size_ff > SIZE_W'(PALETTE_ENTRIES)) ?
                      CNT_W'(PALETTE_ENTRIES) : CNT_W'(palette_size_ff);

   // writes beyond the store are dropped
   assign wr_en = req_fire && (req.opcode == OP_WRITE) &&
                  (SIZE_W'(req.entry_index) < SIZE_W'(PALETTE_ENTRIES));

   npcm_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req.entry_index[ADDR_W-1:0]),
      .wr_data (req.rgb_color),
      .rd_en   (rd_en),
      .rd_addr (scan_ff),
      .rd_data (rd_data)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      rd_en    = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req.opcode == OP_MAP)) begin
               scan_in  = '0;
               // empty palette goes straight to the result with index 0
               state_in = (count_sat == '0) ? ST_DRAIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_en   = 1'b1;
            scan_in = scan_ff + ADDR_W'(1);
            if (CNT_W'(scan_ff) == (count_ff - CNT_W'(1))) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last compare and a free output register
            if (!v1_ff && !v2_ff && (!rsp_valid_ff || rsp.ready)) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         scan_ff         <= '0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         palette_size_ff <= PALETTE_SIZE_RESET;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         v1_ff    <= rd_en;
         v2_ff    <= v1_ff;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            palette_size_ff <= csr_pwdata[SIZE_W-1:0];
         end
      end
   end

   // sum of squared channel distances
   assign dist_sum = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);

   // datapath
   always_ff @(posedge clock) begin
      idx1_ff <= scan_ff;
      idx2_ff <= idx1_ff;
      // squares of the channel differences against the entry just read
      sq_r_ff <= square(abs_diff(color_ff[23:16], rd_data[23:16]));
      sq_g_ff <= square(abs_diff(color_ff[15:8], rd_data[15:8]));
      sq_b_ff <= square(abs_diff(color_ff[7:0], rd_data[7:0]));

      if (req_fire && (req.opcode == OP_MAP)) begin
         color_ff      <= req.rgb_color;
         last_ff       <= req.last_pixel;
         count_ff      <= count_sat;
         first_ff      <= 1'b1;
         best_index_ff <= '0;
         best_dist_ff  <= '0;
      end else if (v2_ff && (first_ff || (dist_sum < best_dist_ff))) begin
         // strict less keeps the lowest index on ties
         first_ff      <= 1'b0;
         best_index_ff <= INDEX_W'(idx2_ff);
         best_dist_ff  <= dist_sum;
      end

      if (out_load) begin
         rsp_index_ff <= best_index_ff;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.palette_index = rsp_index_ff;
   assign rsp.is_last       = rsp_last_ff;

   // pipeline is empty whenever a new request can enter
   `NPCM_ASSERT_IMPLIES(a_idle_drained, clock, reset, state_ff == ST_IDLE, !v1_ff && !v2_ff)

   // ram reads come from the scan only
   `NPCM_ASSERT_NEXT(a_read_in_scan, clock, reset, state_ff != ST_SCAN, !v1_ff)

   // a finished search points inside the searched range
   `NPCM_ASSERT_IMPLIES(a_best_in_range, clock, reset, (state_ff == ST_DRAIN) && !v1_ff && !v2_ff && (count_ff != '0), SIZE_W'(best_index_ff) < SIZE_W'(count_ff))

endmodule
